/* src/dhc_pkg.sv */
// Package of the delay histogram counter: field widths, command and register codes,
// payload structs and the divider status struct. Depends on nothing.
package dhc_pkg;

    localparam int MAX_BUCKETS_DEF = 64;

    localparam int WIDTH_W   = 24;   // bin width register
    localparam int COUNT_W   = 7;    // bucket count register
    localparam int CMD_W     = 2;
    localparam int LEN_W     = 16;
    localparam int DELAY_W   = 32;
    localparam int HITS_W    = 32;
    localparam int TOTAL_W   = 64;
    localparam int DIV_STEPS = DELAY_W;

    localparam logic [CMD_W-1:0] CMD_PLAIN   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DUP     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READOUT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    localparam logic REG_BIN_WIDTH    = 1'b0;
    localparam logic REG_BUCKET_COUNT = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [LEN_W-1:0]   packet_length;
        logic [DELAY_W-1:0] delay;
    } t_in_item;

    typedef struct packed {
        logic [DELAY_W-1:0] bucket_delay;
        logic [HITS_W-1:0]  bucket_hits;
        logic [TOTAL_W-1:0] total_packets;
        logic [TOTAL_W-1:0] dup_packets;
        logic [TOTAL_W-1:0] dup_bytes;
        logic [TOTAL_W-1:0] plain_bytes;
        logic               last_bucket;
    } t_out_item;

    typedef struct packed {
        logic               done;
        logic [DELAY_W-1:0] quotient;
    } t_div_res;

endpackage

/* src/dhc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/dhc_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle, delay over bucket width.
// Depends on dhc_pkg.
module dhc_divider
    import dhc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DELAY_W-1:0] i_dividend,
    input  logic [WIDTH_W-1:0] i_divisor,
    output t_div_res           o_res
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_done, n_done;
    logic [WIDTH_W-1:0] r_rem, n_rem;
    logic [WIDTH_W-1:0] r_dvs, n_dvs;
    logic [DELAY_W-1:0] r_quo, n_quo;
    logic [WIDTH_W:0]   trial;

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        trial  = {r_rem, r_quo[DELAY_W-1]};
        if (i_start) begin
            n_cnt = CNT_W'(DIV_STEPS);
            n_rem = '0;
            n_dvs = i_divisor;
            n_quo = i_dividend;
        end else if (r_cnt != '0) begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = WIDTH_W'(trial - {1'b0, r_dvs});
                n_quo = {r_quo[DELAY_W-2:0], 1'b1};
            end else begin
                n_rem = trial[WIDTH_W-1:0];
                n_quo = {r_quo[DELAY_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_res.done     = r_done;
    assign o_res.quotient = r_quo;

endmodule

/* src/delay_histogram_counter.sv */
// Top level of the delay histogram counter: command port, APB registers, sequencer.
// Depends on dhc_pkg, dhc_divider and dhc_ram.
//
//  channel   ports                                  handshake
//  --------  -------------------------------------  ------------------------------
//  command   start, busy, i_item                    beat taken when start && !busy
//  result    o_result_valid, o_result               one-cycle strobe, no backpressure
//  config    psel penable pwrite paddr pwdata        write at psel&&penable&&pwrite
//            prdata pready                          pready tied high
//
//  A plain packet beat (or the unused command) leaves busy low.
//  A duplicate beat holds busy through the divide step (32 quotient bits, then
//  the done flag), one RAM read and one write of the bumped entry.
//  A readout holds busy through a read step and an emit step per RAM entry,
//  reading and zeroing each; a result beat per bucket in use is registered from
//  its read data in the emit step, so with every bucket in use the last beat
//  comes as busy drops. After reset a clearing pass zeroes the bucket RAM with
//  busy high; register writes are taken meanwhile. The receiver cannot stall.
module delay_histogram_counter
    import dhc_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_result_valid,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CNT_W = $clog2(MAX_BUCKETS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLR    = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_INC_RD = 3'd3;
    localparam logic [2:0] ST_INC_WR = 3'd4;
    localparam logic [2:0] ST_RO_RD  = 3'd5;
    localparam logic [2:0] ST_RO_EM  = 3'd6;

    // ---------------------------------------------------------------- registers
    logic [WIDTH_W-1:0] r_cfg_width;
    logic [COUNT_W-1:0] r_cfg_count;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= WIDTH_W'(1);
            r_cfg_count <= COUNT_W'(64);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_BIN_WIDTH:    r_cfg_width <= pwdata[WIDTH_W-1:0];
                REG_BUCKET_COUNT: r_cfg_count <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BIN_WIDTH:    prdata = 32'(r_cfg_width);
            REG_BUCKET_COUNT: prdata = 32'(r_cfg_count);
            default:          prdata = '0;
        endcase
    end

    // Width zero counts as one; bucket count is forced into 1..MAX_BUCKETS.
    logic [WIDTH_W-1:0] w_use;
    logic [CNT_W-1:0]   cnt_use;
    logic [CNT_W-1:0]   cnt_last;

    assign w_use = (r_cfg_width == '0) ? WIDTH_W'(1) : r_cfg_width;

    always_comb begin
        priority if (r_cfg_count == '0) begin
            cnt_use = CNT_W'(1);
        end else if (r_cfg_count > COUNT_W'(MAX_BUCKETS)) begin
            cnt_use = CNT_W'(MAX_BUCKETS);
        end else begin
            cnt_use = r_cfg_count[CNT_W-1:0];
        end
    end

    assign cnt_last = cnt_use - CNT_W'(1);

    // ---------------------------------------------------------------- datapath
    logic [2:0]         r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [DELAY_W-1:0] r_mid, n_mid;
    logic [TOTAL_W-1:0] r_plain_pk, n_plain_pk;
    logic [TOTAL_W-1:0] r_dup_pk, n_dup_pk;
    logic [TOTAL_W-1:0] r_plain_by, n_plain_by;
    logic [TOTAL_W-1:0] r_dup_by, n_dup_by;
    logic               r_out_vld, n_out_vld;
    t_out_item          r_out, n_out;

    logic               accept;
    logic               div_start;
    t_div_res           div_res;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [HITS_W-1:0]  ram_wdata;
    logic [HITS_W-1:0]  ram_rdata;
    logic               in_use;
    logic               sweep_end;

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign div_start = accept && (i_item.command == CMD_DUP);
    assign in_use    = (CNT_W'(r_idx) < cnt_use);
    assign sweep_end = (r_idx == IDX_W'(MAX_BUCKETS - 1));

    dhc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_item.delay),
        .i_divisor  (w_use),
        .o_res      (div_res)
    );

    dhc_ram #(
        .WIDTH (HITS_W),
        .DEPTH (MAX_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_mid      = r_mid;
        n_plain_pk = r_plain_pk;
        n_dup_pk   = r_dup_pk;
        n_plain_by = r_plain_by;
        n_dup_by   = r_dup_by;
        n_out_vld  = 1'b0;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_item.command)
                        CMD_PLAIN: begin
                            n_plain_pk = r_plain_pk + TOTAL_W'(1);
                            n_plain_by = r_plain_by + TOTAL_W'(i_item.packet_length);
                        end
                        CMD_DUP: begin
                            // totals now, bucket once the divider is done
                            n_dup_pk = r_dup_pk + TOTAL_W'(1);
                            n_dup_by = r_dup_by + TOTAL_W'(i_item.packet_length);
                            n_state  = ST_DIV;
                        end
                        CMD_READOUT: begin
                            n_idx   = '0;
                            n_mid   = DELAY_W'(w_use >> 1);
                            n_state = ST_RO_RD;
                        end
                        CMD_UNUSED: ;
                        default: ;
                    endcase
                end
            end
            ST_CLR: begin
                // zero one entry per cycle after reset
                ram_we = 1'b1;
                n_idx  = r_idx + IDX_W'(1);
                if (sweep_end) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    // clamp the quotient to the last bucket in use
                    if (div_res.quotient > DELAY_W'(cnt_last)) begin
                        n_idx = IDX_W'(cnt_last);
                    end else begin
                        n_idx = div_res.quotient[IDX_W-1:0];
                    end
                    n_state = ST_INC_RD;
                end
            end
            ST_INC_RD: begin
                n_state = ST_INC_WR;
            end
            ST_INC_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata + HITS_W'(1);
                n_state   = ST_IDLE;
            end
            ST_RO_RD: begin
                n_state = ST_RO_EM;
            end
            ST_RO_EM: begin
                // emit the bucket if in use, zero it either way
                ram_we = 1'b1;
                if (in_use) begin
                    n_out_vld             = 1'b1;
                    n_out.bucket_delay    = r_mid;
                    n_out.bucket_hits     = ram_rdata;
                    n_out.total_packets   = r_plain_pk + r_dup_pk;
                    n_out.dup_packets     = r_dup_pk;
                    n_out.dup_bytes       = r_dup_by;
                    n_out.plain_bytes     = r_plain_by;
                    n_out.last_bucket     = (CNT_W'(r_idx) == cnt_last);
                end
                n_mid = r_mid + DELAY_W'(w_use);
                if (sweep_end) begin
                    n_plain_pk = '0;
                    n_dup_pk   = '0;
                    n_plain_by = '0;
                    n_dup_by   = '0;
                    n_state    = ST_IDLE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = ST_RO_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_idx      <= '0;
            r_plain_pk <= '0;
            r_dup_pk   <= '0;
            r_plain_by <= '0;
            r_dup_by   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_plain_pk <= n_plain_pk;
            r_dup_pk   <= n_dup_pk;
            r_plain_by <= n_plain_by;
            r_dup_by   <= n_dup_by;
            r_out_vld  <= n_out_vld;
        end
        r_mid <= n_mid;
        r_out <= n_out;
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

    // ---------------------------------------------------------------- checks
    a_beat_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state) == ST_RO_EM)
        else $error("result beat without a readout step");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last_bucket) |=> !o_result_valid)
        else $error("result beat after the last bucket");

    a_inc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INC_WR) |-> (CNT_W'(r_idx) <= cnt_last))
        else $error("bucket index past the buckets in use");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide step");

endmodule
